@@ hdl/bmsi_pkg.sv @@
// Shared types and constants for the bank mapper with scanline interrupt.
`timescale 1ns / 1ps
`default_nettype none

package bmsi_pkg;

  localparam int PRG_COUNT_W = 9;
  localparam int CHR_COUNT_W = 11;
  localparam int PAGE_W      = 11;
  localparam int BANK_W      = 8;
  localparam int SLOT_W      = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  // Modulo unit: four dividend bits are retired per cycle.
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = BANK_W / MOD_DIGIT_W;
  localparam int MOD_STEP_W  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  localparam logic [SLOT_W-1:0] CHR_FIRST_SLOT = 4'd4;
  localparam logic [SLOT_W-1:0] LAST_SLOT      = 4'd11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [15:0] ADDR_MASK        = 16'hE001;
  localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
  localparam logic [15:0] ADDR_MIRROR      = 16'hA000;
  localparam logic [15:0] ADDR_IRQ_COUNTER = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_DISABLE = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ENABLE  = 16'hE001;

  localparam logic [BANK_W-1:0] BANK_2K_MASK = 8'hFE;
  localparam logic [2:0] SEL_LAST_2K  = 3'd1;
  localparam logic [2:0] SEL_FIRST_1K = 3'd2;
  localparam logic [2:0] SEL_LAST_CHR = 3'd5;
  localparam int PRG_SWAP_BIT = 6;
  localparam int CHR_SWAP_BIT = 7;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_PAGES   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_PAGES   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_SCREEN = 2'd2;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic [7:0]  wdata;
    logic [8:0]  scanline;
    logic        rendering_on;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] page;
    logic              from_chr_ram;
    logic              mirroring;
    logic              irq_request;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              apply;
    logic              mod_start;
    logic              emit;
    logic [SLOT_W-1:0] slot;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/bmsi_mod.sv @@
// Iterative remainder unit: an 8-bit bank number modulo an 11-bit page count.
`timescale 1ns / 1ps
`default_nettype none

module bmsi_mod import bmsi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [BANK_W-1:0] dividend,
  input  wire logic [PAGE_W-1:0] divisor,
  output logic      [PAGE_W-1:0] result,
  output logic                   done
);

  logic [PAGE_W-1:0]     rem;
  logic [PAGE_W-1:0]     rem_next;
  logic [BANK_W-1:0]     dvd;
  logic [BANK_W-1:0]     dvd_next;
  logic [MOD_STEP_W-1:0] step;
  logic                  busy;
  logic                  zero;

  // Restoring remainder, several bits per cycle. The partial remainder stays
  // below the divisor, so one trial subtraction per bit is enough.
  always_comb begin
    logic [PAGE_W:0] trial;
    rem_next = rem;
    dvd_next = dvd;
    for (int i = 0; i < MOD_DIGIT_W; i++) begin
      trial    = {rem_next, dvd_next[BANK_W-1]};
      dvd_next = {dvd_next[BANK_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next = PAGE_W'(trial - {1'b0, divisor});
      end else begin
        rem_next = trial[PAGE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= MOD_STEP_W'(step + 1'b1);
      if (step == MOD_STEP_W'(MOD_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvd  <= dividend;
      zero <= (divisor == '0);
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd_next;
    end
  end

  // An empty page count maps everything to page zero.
  assign result = zero ? '0 : rem;

endmodule

`default_nettype wire

@@ hdl/bmsi_dp.sv @@
// Datapath: mapper registers, IRQ counter, slot page selection and result register.
`timescale 1ns / 1ps
`default_nettype none

module bmsi_dp import bmsi_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctrl_cmd_t              cmd,
  output dp_status_t                  status,
  input  wire item_t                  item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output result_t                     result
);

  logic [PRG_COUNT_W-1:0] prg_count;
  logic [CHR_COUNT_W-1:0] chr_count;
  logic                   four_screen;

  logic [BANK_W-1:0] bank_select;
  logic [BANK_W-1:0] chr_2k_banks [2];
  logic [BANK_W-1:0] chr_1k_banks [4];
  logic [BANK_W-1:0] prg_banks [2];
  logic [BANK_W-1:0] irq_counter;
  logic [BANK_W-1:0] irq_reload;
  logic              irq_enable;
  logic              mirror_mode;
  logic              irq_flag;

  logic [2:0]             sel;
  logic [2:0]             sel_1k;
  logic                   chr_ram;
  logic [PRG_COUNT_W-1:0] prg_last0;
  logic [PRG_COUNT_W-1:0] prg_last1;
  logic                   use_mod;
  logic [PAGE_W-1:0]      fixed_page;
  logic [BANK_W-1:0]      mod_dividend;
  logic [PAGE_W-1:0]      mod_divisor;
  logic [PAGE_W-1:0]      mod_result;
  logic                   mod_done;

  assign sel     = bank_select[2:0];
  assign sel_1k  = sel - SEL_FIRST_1K;
  assign chr_ram = (chr_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count   <= PRG_COUNT_W'(2);
      chr_count   <= '0;
      four_screen <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_PAGES:   prg_count   <= cfg_wdata[PRG_COUNT_W-1:0];
        CFG_CHR_PAGES:   chr_count   <= cfg_wdata[CHR_COUNT_W-1:0];
        CFG_FOUR_SCREEN: four_screen <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select     <= '0;
      chr_2k_banks[0] <= 8'd0;
      chr_2k_banks[1] <= 8'd2;
      chr_1k_banks[0] <= 8'd4;
      chr_1k_banks[1] <= 8'd5;
      chr_1k_banks[2] <= 8'd6;
      chr_1k_banks[3] <= 8'd7;
      prg_banks[0]    <= 8'd0;
      prg_banks[1]    <= 8'd1;
      irq_counter     <= '0;
      irq_reload      <= '0;
      irq_enable      <= 1'b0;
      mirror_mode     <= 1'b0;
      irq_flag        <= 1'b0;
    end else if (cmd.apply) begin
      irq_flag <= 1'b0;
      if (item.command == CMD_WRITE) begin
        case (item.address & ADDR_MASK)
          ADDR_BANK_SELECT: bank_select <= item.wdata;
          ADDR_BANK_DATA: begin
            // Character bank writes are dropped when the cartridge has no CHR ROM.
            if (!(sel <= SEL_LAST_CHR && chr_ram)) begin
              if (sel <= SEL_LAST_2K) begin
                chr_2k_banks[sel[0]] <= item.wdata & BANK_2K_MASK;
              end else if (sel <= SEL_LAST_CHR) begin
                chr_1k_banks[sel_1k[1:0]] <= item.wdata;
              end else begin
                prg_banks[sel[0]] <= item.wdata;
              end
            end
          end
          ADDR_MIRROR: begin
            if (!four_screen) begin
              mirror_mode <= ~item.wdata[0];
            end
          end
          ADDR_IRQ_COUNTER: irq_counter <= item.wdata;
          ADDR_IRQ_RELOAD:  irq_reload  <= item.wdata;
          ADDR_IRQ_DISABLE: irq_enable  <= 1'b0;
          ADDR_IRQ_ENABLE:  irq_enable  <= 1'b1;
          default: ;
        endcase
      end else if (irq_enable && item.scanline <= LAST_VISIBLE_LINE && item.rendering_on) begin
        if (irq_counter == '0) begin
          irq_counter <= irq_reload;
          irq_flag    <= 1'b1;
        end else begin
          irq_counter <= BANK_W'(irq_counter - 1'b1);
        end
      end
    end
  end

  assign prg_last0 = (prg_count != '0) ? PRG_COUNT_W'(prg_count - 1'b1) : '0;
  assign prg_last1 = (prg_count > PRG_COUNT_W'(1)) ? PRG_COUNT_W'(prg_count - 2'd2) : '0;

  // Work out, for the slot in hand, either a fixed page or the bank number
  // that goes through the modulo unit.
  always_comb begin
    logic [SLOT_W-1:0] chr_offset;
    logic [2:0]        c;
    logic [2:0]        e;
    chr_offset   = SLOT_W'(cmd.slot - CHR_FIRST_SLOT);
    c            = chr_offset[2:0];
    e            = c ^ {bank_select[CHR_SWAP_BIT], 2'b00};
    use_mod      = 1'b0;
    fixed_page   = '0;
    mod_dividend = '0;
    mod_divisor  = PAGE_W'(prg_count);
    if (cmd.slot < CHR_FIRST_SLOT) begin
      case (cmd.slot[1:0])
        2'd0: begin
          if (bank_select[PRG_SWAP_BIT]) begin
            fixed_page = PAGE_W'(prg_last1);
          end else begin
            use_mod      = 1'b1;
            mod_dividend = prg_banks[0];
          end
        end
        2'd1: begin
          use_mod      = 1'b1;
          mod_dividend = prg_banks[1];
        end
        2'd2: begin
          if (bank_select[PRG_SWAP_BIT]) begin
            use_mod      = 1'b1;
            mod_dividend = prg_banks[0];
          end else begin
            fixed_page = PAGE_W'(prg_last1);
          end
        end
        default: fixed_page = PAGE_W'(prg_last0);
      endcase
    end else if (chr_ram) begin
      // Character RAM: pages 0-3 and 4-7, swapped by the CHR swap bit.
      fixed_page = PAGE_W'({c[2] ^ ~bank_select[CHR_SWAP_BIT], c[1:0]});
    end else begin
      use_mod     = 1'b1;
      mod_divisor = chr_count;
      case (e)
        3'd0:    mod_dividend = chr_2k_banks[0];
        3'd1:    mod_dividend = BANK_W'(chr_2k_banks[0] + 1'b1);
        3'd2:    mod_dividend = chr_2k_banks[1];
        3'd3:    mod_dividend = BANK_W'(chr_2k_banks[1] + 1'b1);
        default: mod_dividend = chr_1k_banks[e[1:0]];
      endcase
    end
  end

  bmsi_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .result   (mod_result),
    .done     (mod_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.slot         <= cmd.slot;
      result.page         <= use_mod ? mod_result : fixed_page;
      result.from_chr_ram <= chr_ram && (cmd.slot >= CHR_FIRST_SLOT);
      result.mirroring    <= mirror_mode;
      result.irq_request  <= irq_flag;
      result.last         <= (cmd.slot == LAST_SLOT);
    end
  end

  assign status.mod_done = mod_done;
  assign status.out_free = !result_valid || result_ready;

endmodule

`default_nettype wire

@@ hdl/bmsi_ctrl.sv @@
// Controller: accepts an item, then steps through the twelve slots of the page map.
`timescale 1ns / 1ps
`default_nettype none

module bmsi_ctrl import bmsi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_CALC,
    S_EMIT
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_LOAD;
            slot  <= '0;
          end
        end
        S_LOAD: state <= S_CALC;
        S_CALC: begin
          if (status.mod_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (status.out_free) begin
            if (slot == LAST_SLOT) begin
              state <= S_IDLE;
            end else begin
              slot  <= SLOT_W'(slot + 1'b1);
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item_ready    = (state == S_IDLE);
  assign cmd.apply     = item_valid && (state == S_IDLE);
  assign cmd.mod_start = (state == S_LOAD);
  assign cmd.emit      = (state == S_EMIT) && status.out_free;
  assign cmd.slot      = slot;

endmodule

`default_nettype wire

@@ hdl/bank_mapper_with_scanline_irq.sv @@
// Bank-switching mapper with scanline IRQ counter: top level.
//
// Each accepted word is a CPU register write or an end-of-scanline tick; it
// updates the mapper registers in the cycle it is taken and is answered by
// twelve result words giving the page map (four 8K program slots, then eight
// 1K character slots), the mirroring code and whether the word raised an IRQ.
// After the accept cycle the block steps, for each slot, through a load
// state, the shared modulo unit (two steps of four remainder bits each,
// then a step to flag completion) and a state that writes the result
// register. A result still waiting when the next slot is ready to be
// written holds that slot up until it is taken. The next word is taken
// while the last result still waits in the output register. The user must
// write the configuration registers through cfg_we, cfg_index and cfg_wdata
// only while no item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module bank_mapper_with_scanline_irq import bmsi_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire item_t                  item,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output result_t                     result,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bmsi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  bmsi_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Once a word is taken the block is busy until its map has gone out.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("block still ready after taking a word");

  // While idle, only the final word of the previous map may be waiting.
  a_idle_holds_last : assert property (@(posedge clk) disable iff (rst)
    item_ready && result_valid |-> result.last)
    else $error("idle with an unfinished map in the output register");

  a_last_slot : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> result.slot == LAST_SLOT)
    else $error("last flag on a slot other than the final one");

  a_ram_on_chr_only : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.from_chr_ram |-> result.slot >= CHR_FIRST_SLOT)
    else $error("character RAM flag on a program slot");

endmodule

`default_nettype wire
